// File: rtl/planar_pose_compounding_core_defines.svh
// ============================================================================
// planar_pose_compounding_core_defines
// Assertion macros for the pose compounding RTL.
// ============================================================================
`ifndef PLANAR_POSE_COMPOUNDING_CORE_DEFINES_SVH
`define PLANAR_POSE_COMPOUNDING_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define PPC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ppc_pkg.sv
// ============================================================================
// ppc_pkg
// Widths, types and the arctangent table of the planar pose compounding core.
// ============================================================================
`default_nettype none

package ppc_pkg;

    // Field widths
    localparam int POSITION_WIDTH = 32;
    localparam int ANGLE_WIDTH    = 16;

    // CORDIC datapath: 32-bit binary angle, Q2.30 coordinates
    localparam int CORDIC_W     = 32;
    localparam int CORDIC_STEPS = 30;
    localparam int COEF_FRAC    = 30;
    localparam logic signed [CORDIC_W-1:0] CORDIC_START = 32'sd652032874;
    localparam logic signed [CORDIC_W-1:0] QUARTER_TURN = CORDIC_W'(1) << (CORDIC_W - 2);

    // atan(2^-i) in units of 2^-32 turns
    localparam logic [CORDIC_W-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    // Derived datapath widths
    localparam int DIFF_W = POSITION_WIDTH + 1;
    localparam int PROD_W = DIFF_W + CORDIC_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int SHR_W  = SUM_W - COEF_FRAC;
    localparam int RES_W  = SHR_W + 1;

    // Operation codes
    typedef enum logic {
        PPC_OP_OPLUS  = 1'b0,
        PPC_OP_OMINUS = 1'b1
    } ppc_op_t;

    // Sideband carried alongside the CORDIC stages
    typedef struct packed {
        ppc_op_t                   op;
        logic                      flip;
        logic [DIFF_W-1:0]         p;
        logic [DIFF_W-1:0]         q;
        logic [POSITION_WIDTH-1:0] ox;
        logic [POSITION_WIDTH-1:0] oy;
        logic [ANGLE_WIDTH-1:0]    hd;
    } ppc_side_t;

    // One finished result word
    typedef struct packed {
        logic [POSITION_WIDTH-1:0] cx;
        logic [POSITION_WIDTH-1:0] cy;
        logic [ANGLE_WIDTH-1:0]    hd;
        logic                      ov;
    } ppc_result_t;

endpackage

`default_nettype wire

// File: rtl/planar_pose_compounding_core.sv
// ============================================================================
// planar_pose_compounding_core
// Fixed-point SE(2) pose composition and inverse composition, fully pipelined.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall) carries opcode and poses a and b.
//   Opcode oplus maps pose a from b's frame into the global frame; opcode
//   ominus expresses global pose a in b's frame. The output channel
//   (out_valid / out_stall) returns c_x, c_y (Q16.16, saturated), c_heading
//   (binary angle, wraps modulo a full turn) and overflow.
//   The accepting edge loads the input stage; the word then passes 30
//   CORDIC stages (one rotation each), a coefficient stage, a multiply
//   stage, a sum stage and the output register before out_valid rises.
//   Throughput: one word per cycle while the receiver does not stall, set by
//   the one-rotation-per-stage CORDIC and the registered 33x32 multipliers.
//   When the receiver stalls, the next word lands in a one-entry skid
//   register; in_stall rises only while that skid entry is full, and the
//   whole pipeline then holds until the output word is taken.
//   Reset clears all valid bits and the output and skid flags; the block is
//   ready in the first cycle after reset is released.
// ============================================================================
`default_nettype none

`include "planar_pose_compounding_core_defines.svh"

module planar_pose_compounding_core (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic                                      opcode,
    input  logic signed [ppc_pkg::POSITION_WIDTH-1:0] a_x,
    input  logic signed [ppc_pkg::POSITION_WIDTH-1:0] a_y,
    input  logic signed [ppc_pkg::ANGLE_WIDTH-1:0]    a_heading,
    input  logic signed [ppc_pkg::POSITION_WIDTH-1:0] b_x,
    input  logic signed [ppc_pkg::POSITION_WIDTH-1:0] b_y,
    input  logic signed [ppc_pkg::ANGLE_WIDTH-1:0]    b_heading,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic signed [ppc_pkg::POSITION_WIDTH-1:0] c_x,
    output logic signed [ppc_pkg::POSITION_WIDTH-1:0] c_y,
    output logic signed [ppc_pkg::ANGLE_WIDTH-1:0]    c_heading,
    output logic                                      overflow
);

    import ppc_pkg::*;

    localparam int CW = CORDIC_W;
    localparam int PW = POSITION_WIDTH;

    // Saturation bounds at result width
    localparam logic signed [RES_W-1:0] POS_MAX =
        {{(RES_W - PW + 1){1'b0}}, {(PW - 1){1'b1}}};
    localparam logic signed [RES_W-1:0] POS_MIN =
        {{(RES_W - PW + 1){1'b1}}, {(PW - 1){1'b0}}};
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (COEF_FRAC - 1);

    // Pipeline advances whenever the skid entry is free
    logic en;
    logic in_accept;
    logic skid_valid_reg;

    assign en        = !skid_valid_reg;
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;

    // ------------------------------------------------------------------
    // Input stage: quadrant fold of b's heading, differences, offsets
    // ------------------------------------------------------------------
    logic signed [CW-1:0] ang_in;
    logic                 flip_in;
    logic signed [CW-1:0] z_in;
    ppc_side_t            side_in;
    logic                 ominus_in;

    always_comb
    begin
        ang_in    = {b_heading, {(CW - ANGLE_WIDTH){1'b0}}};
        flip_in   = (ang_in > QUARTER_TURN) || (ang_in < -QUARTER_TURN);
        // +-180 degrees is a flip of the top bit
        z_in      = flip_in ? {~ang_in[CW-1], ang_in[CW-2:0]} : ang_in;
        ominus_in = (ppc_op_t'(opcode) == PPC_OP_OMINUS);

        side_in.op   = ppc_op_t'(opcode);
        side_in.flip = flip_in;
        if (ominus_in)
        begin
            side_in.p  = DIFF_W'(a_x) - DIFF_W'(b_x);
            side_in.q  = DIFF_W'(a_y) - DIFF_W'(b_y);
            side_in.ox = '0;
            side_in.oy = '0;
            side_in.hd = a_heading - b_heading;
        end
        else
        begin
            side_in.p  = DIFF_W'(a_x);
            side_in.q  = DIFF_W'(a_y);
            side_in.ox = b_x;
            side_in.oy = b_y;
            side_in.hd = a_heading + b_heading;
        end
    end

    // CORDIC stage registers, index 0 is the input stage
    logic                 vld_reg  [CORDIC_STEPS+1];
    logic signed [CW-1:0] x_reg    [CORDIC_STEPS+1];
    logic signed [CW-1:0] y_reg    [CORDIC_STEPS+1];
    logic signed [CW-1:0] z_reg    [CORDIC_STEPS+1];
    ppc_side_t            side_reg [CORDIC_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= CORDIC_START;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_in;
            side_reg[0] <= side_in;
        end
    end

    // ------------------------------------------------------------------
    // CORDIC rotation stages, one micro-rotation each
    // ------------------------------------------------------------------
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        logic signed [CW-1:0] x_next;
        logic signed [CW-1:0] y_next;
        logic signed [CW-1:0] z_next;

        always_comb
        begin
            xs = x_reg[i] >>> i;
            ys = y_reg[i] >>> i;
            if (!z_reg[i][CW-1])
            begin
                x_next = x_reg[i] - ys;
                y_next = y_reg[i] + xs;
                z_next = z_reg[i] - $signed(ATAN_TABLE[i]);
            end
            else
            begin
                x_next = x_reg[i] + ys;
                y_next = y_reg[i] - xs;
                z_next = z_reg[i] + $signed(ATAN_TABLE[i]);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                z_reg[i+1]    <= z_next;
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Coefficient stage: undo the fold and apply the rotation sense
    // ------------------------------------------------------------------
    ppc_side_t            side_last;
    logic signed [CW-1:0] cx_last;
    logic signed [CW-1:0] sy_last;
    logic                 neg_mx;
    logic                 neg_ky;

    assign side_last = side_reg[CORDIC_STEPS];
    assign cx_last   = x_reg[CORDIC_STEPS];
    assign sy_last   = y_reg[CORDIC_STEPS];
    // oplus uses -sin for x, ominus uses -sin for y
    assign neg_mx    = side_last.flip ^ (side_last.op == PPC_OP_OPLUS);
    assign neg_ky    = side_last.flip ^ (side_last.op == PPC_OP_OMINUS);

    logic                     vld_c_reg;
    logic signed [CW-1:0]     kc_reg;
    logic signed [CW-1:0]     mx_reg;
    logic signed [CW-1:0]     ky_reg;
    logic signed [DIFF_W-1:0] p_c_reg;
    logic signed [DIFF_W-1:0] q_c_reg;
    logic [PW-1:0]            ox_c_reg;
    logic [PW-1:0]            oy_c_reg;
    logic [ANGLE_WIDTH-1:0]   hd_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_c_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_c_reg <= vld_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kc_reg   <= side_last.flip ? -cx_last : cx_last;
            mx_reg   <= neg_mx ? -sy_last : sy_last;
            ky_reg   <= neg_ky ? -sy_last : sy_last;
            p_c_reg  <= $signed(side_last.p);
            q_c_reg  <= $signed(side_last.q);
            ox_c_reg <= side_last.ox;
            oy_c_reg <= side_last.oy;
            hd_c_reg <= side_last.hd;
        end
    end

    // ------------------------------------------------------------------
    // Multiply stage: four 33x32 products
    // ------------------------------------------------------------------
    logic                     vld_m_reg;
    logic signed [PROD_W-1:0] pkx_reg;
    logic signed [PROD_W-1:0] qmx_reg;
    logic signed [PROD_W-1:0] pky_reg;
    logic signed [PROD_W-1:0] qmy_reg;
    logic [PW-1:0]            ox_m_reg;
    logic [PW-1:0]            oy_m_reg;
    logic [ANGLE_WIDTH-1:0]   hd_m_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_m_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_m_reg <= vld_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pkx_reg  <= PROD_W'(p_c_reg) * PROD_W'(kc_reg);
            qmx_reg  <= PROD_W'(q_c_reg) * PROD_W'(mx_reg);
            pky_reg  <= PROD_W'(p_c_reg) * PROD_W'(ky_reg);
            qmy_reg  <= PROD_W'(q_c_reg) * PROD_W'(kc_reg);
            ox_m_reg <= ox_c_reg;
            oy_m_reg <= oy_c_reg;
            hd_m_reg <= hd_c_reg;
        end
    end

    // ------------------------------------------------------------------
    // Sum stage: dot products plus rounding half
    // ------------------------------------------------------------------
    logic                    vld_s_reg;
    logic signed [SUM_W-1:0] sx_reg;
    logic signed [SUM_W-1:0] sy_reg;
    logic [PW-1:0]           ox_s_reg;
    logic [PW-1:0]           oy_s_reg;
    logic [ANGLE_WIDTH-1:0]  hd_s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_s_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_s_reg <= vld_m_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg   <= SUM_W'(pkx_reg) + SUM_W'(qmx_reg) + ROUND_HALF;
            sy_reg   <= SUM_W'(pky_reg) + SUM_W'(qmy_reg) + ROUND_HALF;
            ox_s_reg <= ox_m_reg;
            oy_s_reg <= oy_m_reg;
            hd_s_reg <= hd_m_reg;
        end
    end

    // ------------------------------------------------------------------
    // Offset add and saturation, feeding the output register
    // ------------------------------------------------------------------
    logic signed [RES_W-1:0] rx;
    logic signed [RES_W-1:0] ry;
    logic                    hi_x;
    logic                    lo_x;
    logic                    hi_y;
    logic                    lo_y;
    ppc_result_t             fin;

    always_comb
    begin
        rx   = RES_W'($signed(sx_reg[SUM_W-1:COEF_FRAC])) + RES_W'($signed(ox_s_reg));
        ry   = RES_W'($signed(sy_reg[SUM_W-1:COEF_FRAC])) + RES_W'($signed(oy_s_reg));
        hi_x = rx > POS_MAX;
        lo_x = rx < POS_MIN;
        hi_y = ry > POS_MAX;
        lo_y = ry < POS_MIN;

        fin.cx = hi_x ? POS_MAX[PW-1:0] : (lo_x ? POS_MIN[PW-1:0] : rx[PW-1:0]);
        fin.cy = hi_y ? POS_MAX[PW-1:0] : (lo_y ? POS_MIN[PW-1:0] : ry[PW-1:0]);
        fin.hd = hd_s_reg;
        fin.ov = hi_x || lo_x || hi_y || lo_y;
    end

    // ------------------------------------------------------------------
    // Output register with one-entry skid
    // ------------------------------------------------------------------
    logic        out_valid_reg;
    ppc_result_t out_reg;
    ppc_result_t skid_reg;
    logic        load_out;

    assign load_out = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!skid_valid_reg)
        begin
            if (vld_s_reg)
            begin
                if (load_out)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
        else if (!out_stall)
        begin
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
        begin
            if (vld_s_reg)
            begin
                if (load_out)
                begin
                    out_reg <= fin;
                end
                else
                begin
                    skid_reg <= fin;
                end
            end
        end
        else if (!out_stall)
        begin
            out_reg <= skid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign c_x       = out_reg.cx;
    assign c_y       = out_reg.cy;
    assign c_heading = out_reg.hd;
    assign overflow  = out_reg.ov;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PPC_ASSERT_SAME(a_skid_needs_out, clk, rst_n, skid_valid_reg, out_valid_reg,
        "skid entry full while output register empty")
    `PPC_ASSERT_NEXT(a_accept_enters, clk, rst_n, in_accept, vld_reg[0],
        "accepted word did not enter the input stage")
    `PPC_ASSERT_NEXT(a_skid_holds, clk, rst_n, skid_valid_reg && out_stall, skid_valid_reg,
        "skid entry dropped while the receiver stalls")
    `PPC_ASSERT_SAME(a_ovf_at_bound, clk, rst_n, out_valid_reg && out_reg.ov,
        (out_reg.cx == POS_MAX[PW-1:0]) || (out_reg.cx == POS_MIN[PW-1:0]) ||
        (out_reg.cy == POS_MAX[PW-1:0]) || (out_reg.cy == POS_MIN[PW-1:0]),
        "overflow flagged without a saturated position")

endmodule

`default_nettype wire

// File: sim/planar_pose_compounding_core_test.sv
// ============================================================================
// planar_pose_compounding_core_test
// Drives pose pairs through the compounding core and checks every result word
// against a bit-exact CORDIC predictor or a typed-in result. A short directed
// table comes first: zero poses, saturating extremes, heading wrap at pi and
// the quarter-turn folds. A long random run follows, with idle gaps on the
// input side and stalls on the output side.
// ============================================================================
`default_nettype none

module planar_pose_compounding_core_test;

    import ppc_pkg::*;

    localparam int PW = POSITION_WIDTH;
    localparam int AW = ANGLE_WIDTH;

    localparam logic signed [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0] POS_MIN = {1'b1, {(PW-1){1'b0}}};
    localparam logic signed [AW-1:0] HD_PI   = {1'b1, {(AW-1){1'b0}}};

    localparam int RANDOM_PAIRS = 1600;
    localparam int DRAIN_CYCLES = 60;

    // Rotation-mode CORDIC constants: gain reciprocal in Q2.30, turns in 2^-32
    localparam longint ROT_GAIN_INV = 64'sd652032874;
    localparam longint QUARTER      = 64'sh40000000;
    localparam longint HALF_TURN    = 64'sh80000000;
    localparam int     ROT_STEPS    = 30;
    localparam longint ATAN_TURNS [ROT_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef struct {
        ppc_op_t               op;
        logic signed [PW-1:0]  ax;
        logic signed [PW-1:0]  ay;
        logic signed [AW-1:0]  ah;
        logic signed [PW-1:0]  bx;
        logic signed [PW-1:0]  by;
        logic signed [AW-1:0]  bh;
    } pose_pair_t;

    // One directed row; fixed rows carry their result typed in
    typedef struct {
        pose_pair_t  stim;
        bit          fixed;
        ppc_result_t want;
    } pose_row_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic                 opcode    = 1'b0;
    logic signed [PW-1:0] a_x       = '0;
    logic signed [PW-1:0] a_y       = '0;
    logic signed [AW-1:0] a_heading = '0;
    logic signed [PW-1:0] b_x       = '0;
    logic signed [PW-1:0] b_y       = '0;
    logic signed [AW-1:0] b_heading = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic signed [PW-1:0] c_x;
    logic signed [PW-1:0] c_y;
    logic signed [AW-1:0] c_heading;
    logic                 overflow;

    ppc_result_t poses_in_flight[$];
    pose_row_t   stim_rows[$];

    int  mismatches   = 0;
    int  words_seen   = 0;
    int  saturations  = 0;
    int  n_compose    = 0;
    int  n_inverse    = 0;
    bit  calm_in      = 1'b0;
    bit  calm_out     = 1'b0;

    planar_pose_compounding_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .a_x       (a_x),
        .a_y       (a_y),
        .a_heading (a_heading),
        .b_x       (b_x),
        .b_y       (b_y),
        .b_heading (b_heading),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .c_x       (c_x),
        .c_y       (c_y),
        .c_heading (c_heading),
        .overflow  (overflow)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // round((p*k + q*m) / 2^30), half up, exact in 96 bits
    function automatic longint rot_round(input longint p, input longint k,
                                         input longint q, input longint m);
        logic signed [95:0] pw;
        logic signed [95:0] kw;
        logic signed [95:0] qw;
        logic signed [95:0] mw;
        logic signed [95:0] acc;
        pw  = 96'(p);
        kw  = 96'(k);
        qw  = 96'(q);
        mw  = 96'(m);
        acc = pw * kw + qw * mw + 96'sd536870912;
        return longint'(acc >>> 30);
    endfunction

    function automatic logic signed [PW-1:0] clamp_pos(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (PW - 1)) - 1;
        lo = -(longint'(1) <<< (PW - 1));
        if (v > hi)
            return hi[PW-1:0];
        if (v < lo)
            return lo[PW-1:0];
        return v[PW-1:0];
    endfunction

    function automatic ppc_result_t compound_pose(input pose_pair_t pr);
        logic signed [31:0] ang;
        longint z;
        longint x;
        longint y;
        longint xs;
        longint ys;
        longint cs;
        longint sn;
        longint rx;
        longint ry;
        longint dx;
        longint dy;
        bit     flip;
        logic signed [PW-1:0] cx;
        logic signed [PW-1:0] cy;
        logic [AW-1:0] hd;
        ppc_result_t res;

        // sine and cosine of b's heading; fold beyond a quarter turn
        ang  = {pr.bh, {(32 - AW){1'b0}}};
        z    = longint'(ang);
        x    = ROT_GAIN_INV;
        y    = 0;
        flip = 1'b0;
        if (z > QUARTER) begin
            z    = z - HALF_TURN;
            flip = 1'b1;
        end
        else if (z < -QUARTER) begin
            z    = z + HALF_TURN;
            flip = 1'b1;
        end
        for (int i = 0; i < ROT_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_TURNS[i];
            end
            else begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_TURNS[i];
            end
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;

        // rotate and offset
        if (pr.op == PPC_OP_OPLUS) begin
            rx = longint'(pr.bx) + rot_round(pr.ax, cs, pr.ay, -sn);
            ry = longint'(pr.by) + rot_round(pr.ax, sn, pr.ay, cs);
            hd = pr.ah + pr.bh;
        end
        else begin
            dx = longint'(pr.ax) - longint'(pr.bx);
            dy = longint'(pr.ay) - longint'(pr.by);
            rx = rot_round(dx, cs, dy, sn);
            ry = rot_round(dx, -sn, dy, cs);
            hd = pr.ah - pr.bh;
        end
        cx     = clamp_pos(rx);
        cy     = clamp_pos(ry);
        res.cx = cx;
        res.cy = cy;
        res.hd = hd;
        res.ov = (longint'(cx) != rx) || (longint'(cy) != ry);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Random content
    // ------------------------------------------------------------------

    // Idle length: mostly none or short, a few long
    function automatic int idle_len(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [PW-1:0] random_pos();
        int r;
        int t;
        logic signed [PW-1:0] v;
        r = $urandom_range(0, 9);
        if (r < 4)
            v = $urandom;
        else if (r < 8) begin
            t = $urandom_range(0, 32'h0020_0000);
            v = t - 32'sh0010_0000;
        end
        else if (r == 8)
            v = POS_MAX - $urandom_range(0, 65535);
        else
            v = POS_MIN + $urandom_range(0, 65535);
        return v;
    endfunction

    function automatic logic signed [AW-1:0] random_heading();
        logic signed [AW-1:0] h;
        if ($urandom_range(0, 9) < 7)
            h = AW'($urandom);
        else begin
            case ($urandom_range(0, 7))
                0:       h = 16'sd0;
                1:       h = 16'sd16384;
                2:       h = -16'sd16384;
                3:       h = HD_PI;
                4:       h = 16'sd32767;
                5:       h = 16'sd16385;
                6:       h = -16'sd16385;
                default: h = 16'sd1;
            endcase
        end
        return h;
    endfunction

    function automatic pose_pair_t random_pair();
        pose_pair_t pr;
        pr.op = ppc_op_t'($urandom_range(0, 1));
        pr.ax = random_pos();
        pr.ay = random_pos();
        pr.ah = random_heading();
        pr.bx = random_pos();
        pr.by = random_pos();
        pr.bh = random_heading();
        return pr;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Present one pair, hold it through stalls, log its result on acceptance
    task automatic offer_pair(input pose_pair_t pr, input ppc_result_t want);
        int gap;
        gap = idle_len(calm_in);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= pr.op;
        a_x       <= pr.ax;
        a_y       <= pr.ay;
        a_heading <= pr.ah;
        b_x       <= pr.bx;
        b_y       <= pr.by;
        b_heading <= pr.bh;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        poses_in_flight.push_back(want);
        if (pr.op == PPC_OP_OPLUS)
            n_compose++;
        else
            n_inverse++;
    endtask

    // clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial begin
        #40000000;
        $display("planar_pose_compounding_core verification failed");
        $finish;
    end

    // stimulus and end of run
    initial begin
        pose_pair_t pr;

        // directed rows
        stim_rows.push_back('{'{PPC_OP_OPLUS, 0, 0, 0, 0, 0, 0},
                              1'b1, '{32'sd0, 32'sd0, 16'sd0, 1'b0}});
        stim_rows.push_back('{'{PPC_OP_OMINUS, 0, 0, 0, 0, 0, 0},
                              1'b1, '{32'sd0, 32'sd0, 16'sd0, 1'b0}});
        // saturation at both bounds, heading zero
        stim_rows.push_back('{'{PPC_OP_OPLUS, POS_MAX, POS_MAX, 0, POS_MAX, POS_MAX, 0},
                              1'b1, '{POS_MAX, POS_MAX, 16'sd0, 1'b1}});
        stim_rows.push_back('{'{PPC_OP_OPLUS, POS_MIN, POS_MIN, 0, POS_MIN, POS_MIN, 0},
                              1'b1, '{POS_MIN, POS_MIN, 16'sd0, 1'b1}});
        stim_rows.push_back('{'{PPC_OP_OMINUS, POS_MAX, POS_MAX, 0, POS_MIN, POS_MIN, 0},
                              1'b1, '{POS_MAX, POS_MAX, 16'sd0, 1'b1}});
        stim_rows.push_back('{'{PPC_OP_OMINUS, POS_MIN, POS_MIN, 0, POS_MAX, POS_MAX, 0},
                              1'b1, '{POS_MIN, POS_MIN, 16'sd0, 1'b1}});
        // heading sum or difference of exactly pi wraps to the negative code
        stim_rows.push_back('{'{PPC_OP_OPLUS, POS_MAX, POS_MAX, 32767, POS_MAX, POS_MAX, 1},
                              1'b1, '{POS_MAX, POS_MAX, HD_PI, 1'b1}});
        stim_rows.push_back('{'{PPC_OP_OMINUS, POS_MAX, POS_MAX, 16384,
                                POS_MIN, POS_MIN, -16384},
                              1'b1, '{POS_MIN, POS_MAX, HD_PI, 1'b1}});
        // a pose seen from itself
        stim_rows.push_back('{'{PPC_OP_OMINUS, 32'sh0003_0039, -32'sh0012_8000, 5000,
                                32'sh0003_0039, -32'sh0012_8000, 5000},
                              1'b1, '{32'sd0, 32'sd0, 16'sd0, 1'b0}});
        // quarter turns, half turn and the fold just past a quarter
        stim_rows.push_back('{'{PPC_OP_OPLUS, 32'sh0001_0000, 0, 0, 0, 0, 16384},
                              1'b0, '{0, 0, 0, 0}});
        stim_rows.push_back('{'{PPC_OP_OPLUS, 32'sh0001_0000, 32'sh0002_0000, 100,
                                32'sh0005_0000, -32'sh0003_0000, HD_PI},
                              1'b0, '{0, 0, 0, 0}});
        stim_rows.push_back('{'{PPC_OP_OPLUS, -32'sh0007_1234, 32'sh0000_8000, -200,
                                32'sh0100_0000, 32'sh0000_0001, 32767},
                              1'b0, '{0, 0, 0, 0}});
        stim_rows.push_back('{'{PPC_OP_OPLUS, 32'sh0010_0000, 32'sh0010_0000, 0,
                                0, 0, 16385},
                              1'b0, '{0, 0, 0, 0}});
        stim_rows.push_back('{'{PPC_OP_OMINUS, 32'sh0010_0000, -32'sh0020_0000, 0,
                                -32'sh0001_0000, 0, -16385},
                              1'b0, '{0, 0, 0, 0}});
        stim_rows.push_back('{'{PPC_OP_OMINUS, 32'sh0123_4567, 32'sh0765_4321, 7000,
                                -32'sh0011_1111, 32'sh0022_2222, 8192},
                              1'b0, '{0, 0, 0, 0}});
        // just inside and just past the positive bound
        stim_rows.push_back('{'{PPC_OP_OPLUS, 32'sh0000_8000, 0, 0,
                                POS_MAX - 32'sh0001_0000, 0, 0},
                              1'b0, '{0, 0, 0, 0}});
        stim_rows.push_back('{'{PPC_OP_OPLUS, 32'sh0001_0000, 0, 0,
                                POS_MAX - 10, POS_MIN + 10, 0},
                              1'b0, '{0, 0, 0, 0}});
        stim_rows.push_back('{'{PPC_OP_OMINUS, -32'sh0040_0000, 32'sh0040_0000, HD_PI,
                                32'sh0020_0000, 32'sh0030_0000, HD_PI},
                              1'b0, '{0, 0, 0, 0}});
        stim_rows.push_back('{'{PPC_OP_OPLUS, POS_MAX, POS_MAX, 32767,
                                POS_MIN, POS_MIN, 0},
                              1'b0, '{0, 0, 0, 0}});
        // alternating bit patterns in every field
        stim_rows.push_back('{'{PPC_OP_OMINUS, 32'sh5555_5555, 32'shAAAA_AAAA, 16'sh5555,
                                32'shAAAA_AAAA, 32'sh5555_5555, 16'shAAAA},
                              1'b0, '{0, 0, 0, 0}});
        stim_rows.push_back('{'{PPC_OP_OPLUS, 32'shAAAA_AAAA, 32'sh5555_5555, 16'shAAAA,
                                32'sh5555_5555, 32'shAAAA_AAAA, 16'sh5555},
                              1'b0, '{0, 0, 0, 0}});

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (stim_rows[i])
            offer_pair(stim_rows[i].stim,
                       stim_rows[i].fixed ? stim_rows[i].want
                                          : compound_pose(stim_rows[i].stim));

        // random pairs, input idling re-decided in blocks
        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            if (n % 64 == 0)
                calm_in = ($urandom_range(0, 3) == 0);
            pr = random_pair();
            offer_pair(pr, compound_pose(pr));
        end
        in_valid <= 1'b0;

        // drain
        while (poses_in_flight.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d pose pairs (%0d compose, %0d inverse), %0d directed",
                 n_compose + n_inverse, n_compose, n_inverse, stim_rows.size());
        $display("checked %0d result words, %0d of them saturated, %0d mismatches",
                 words_seen, saturations, mismatches);
        if (mismatches == 0)
            $display("planar_pose_compounding_core verification clean");
        else
            $display("planar_pose_compounding_core verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // receiver stalls: short bursts, a few long ones, calm stretches
    initial begin
        int s;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if ($urandom_range(0, 49) == 0)
                calm_out = ($urandom_range(0, 2) == 0);
            s = idle_len(calm_out);
            if (s > 0) begin
                out_stall <= 1'b1;
                repeat (s) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // compare each taken word with the oldest prediction
    always @(posedge clk) begin : result_check
        ppc_result_t want;
        ppc_result_t got;
        if (rst_n && out_valid && !out_stall) begin
            got = '{c_x, c_y, c_heading, overflow};
            words_seen++;
            if (overflow === 1'b1)
                saturations++;
            if (poses_in_flight.size() == 0) begin
                mismatches++;
                $display("%0t: result word with none expected: c_x %0d c_y %0d hd %0d ov %0b",
                         $time, $signed(got.cx), $signed(got.cy), $signed(got.hd), got.ov);
            end
            else begin
                want = poses_in_flight.pop_front();
                if (got !== want) begin
                    mismatches++;
                    $display({"%0t: expected c_x %0d c_y %0d hd %0d ov %0b, ",
                              "got c_x %0d c_y %0d hd %0d ov %0b"},
                             $time, $signed(want.cx), $signed(want.cy),
                             $signed(want.hd), want.ov, $signed(got.cx),
                             $signed(got.cy), $signed(got.hd), got.ov);
                end
            end
        end
    end

endmodule

`default_nettype wire
